/* rtl/mmbd_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, target codes, types and address decode for the bus decoder.
package mmbd_pkg;

  localparam int VramBytes          = 8192;
  localparam int WramBytes          = 8192;
  localparam int MainDepth          = VramBytes + WramBytes;
  localparam int MainAw             = $clog2(MainDepth);
  localparam int ClrAw              = $clog2(VramBytes);
  localparam int SmallDepth         = 512;
  localparam int SmallAw            = $clog2(SmallDepth);
  localparam int HramSlots          = 128;
  localparam int HramAw             = $clog2(HramSlots);
  localparam int DefaultRomBankBits = 8;

  localparam logic [3:0] TGT_VRAM   = 4'd0;
  localparam logic [3:0] TGT_WRAM   = 4'd1;
  localparam logic [3:0] TGT_OAM    = 4'd2;
  localparam logic [3:0] TGT_HRAM   = 4'd3;
  localparam logic [3:0] TGT_IE     = 4'd4;
  localparam logic [3:0] TGT_ROM    = 4'd5;
  localparam logic [3:0] TGT_MAPPER = 4'd6;
  localparam logic [3:0] TGT_IO     = 4'd7;
  localparam logic [3:0] TGT_UNUSED = 4'd8;

  typedef struct packed {
    logic               en;
    logic               we;
    logic               side;
    logic [MainAw-1:0]  main_idx;
    logic [SmallAw-1:0] small_idx;
    logic [7:0]         wdata;
  } mem_req_t;

  typedef struct packed {
    logic [3:0]         target;
    logic               has_cell;
    logic               side;
    logic [MainAw-1:0]  main_idx;
    logic [SmallAw-1:0] small_idx;
  } dec_t;

  // small store: OAM at 0..159, high RAM and IE at 256..383 (IE in the last slot)
  function automatic dec_t decode(input logic [15:0] addr, input logic wr);
    dec_t d;
    d.target    = TGT_UNUSED;
    d.has_cell  = 1'b0;
    d.side      = 1'b0;
    d.main_idx  = '0;
    d.small_idx = '0;
    if (addr < 16'h8000) begin
      d.target = wr ? TGT_MAPPER : TGT_ROM;
    end else if (addr < 16'hA000) begin
      d.target   = TGT_VRAM;
      d.has_cell = 1'b1;
      d.main_idx = {1'b0, addr[12:0]};
    end else if (addr < 16'hC000) begin
      d.target = TGT_MAPPER;
    end else if (addr < 16'hFE00) begin
      d.target   = TGT_WRAM;
      d.has_cell = 1'b1;
      d.main_idx = {1'b1, addr[12:0]};
    end else if (addr < 16'hFEA0) begin
      d.target    = TGT_OAM;
      d.has_cell  = 1'b1;
      d.side      = 1'b1;
      d.small_idx = {1'b0, addr[7:0]};
    end else if (addr >= 16'hFF00 && addr < 16'hFF4C) begin
      d.target = TGT_IO;
    end else if (addr >= 16'hFF80) begin
      d.target    = (addr == 16'hFFFF) ? TGT_IE : TGT_HRAM;
      d.has_cell  = 1'b1;
      d.side      = 1'b1;
      d.small_idx = {2'b10, addr[6:0]};
    end
    return d;
  endfunction

endpackage

/* rtl/memory_map_bus_decoder_top.sv */
`timescale 1ns / 1ps
// Top level of the byte bus decoder for the 8-bit machine memory map.
//
// Input channel (in_valid/in_ready): one byte read or write per transfer,
// with func, address, write_data and the mapper's rom_bank.
// Output channel (out_valid/out_ready): exactly one result per input transfer,
// in order: target, read_data, rom_address, io_index, forward_write, forward_data.
// Video RAM and work RAM share one 16K x 8 memory; OAM, high RAM and the
// interrupt-enable byte share a 512 x 8 memory. Both have a registered read.
// Throughput: one transfer per cycle while the receiver takes results and no
// clear pass runs. The input transfer loads the read stage and starts the
// memory read; the result register loads from the read stage when it moves on.
// Reset: a clear pass zeroes video RAM, one byte a cycle; in_ready stays low
// meanwhile. High RAM and interrupt enable read zero until written.
// A stalled receiver holds the result register; one more item waits in the
// read stage, and in_ready drops until the result is taken.
module memory_map_bus_decoder_top #(
  parameter int ROM_BANK_BITS = mmbd_pkg::DefaultRomBankBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  rom_bank,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  target,
  output logic [7:0]  read_data,
  output logic [21:0] rom_address,
  output logic [6:0]  io_index,
  output logic        forward_write,
  output logic [7:0]  forward_data
);

  mmbd_pkg::dec_t     dec;
  mmbd_pkg::mem_req_t req;
  logic [7:0]         mem_rdata;
  logic               busy;
  logic               accept;
  logic               s1_move;
  logic [7:0]         bank_m;
  logic [21:0]        rom_calc;

  logic        s1_valid;
  logic [3:0]  s1_target;
  logic        s1_rd;
  logic [21:0] s1_rom;
  logic [6:0]  s1_io;
  logic        s1_fw;
  logic [7:0]  s1_fd;

  assign dec     = mmbd_pkg::decode(address, func);
  assign s1_move = s1_valid && (!out_valid || out_ready);
  assign in_ready = !busy && (!s1_valid || s1_move);
  assign accept  = in_valid && in_ready;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      bank_m[i] = rom_bank[i] && (i < ROM_BANK_BITS);
    end
    if (bank_m == 8'd0) begin
      bank_m = 8'd1;
    end
    if (address[15:14] == 2'b00) begin
      rom_calc = {8'd0, address[13:0]};
    end else begin
      rom_calc = {bank_m, address[13:0]};
    end
  end

  always_comb begin
    req.en        = accept && dec.has_cell;
    req.we        = func;
    req.side      = dec.side;
    req.main_idx  = dec.main_idx;
    req.small_idx = dec.small_idx;
    req.wdata     = write_data;
  end

  mmbd_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (mem_rdata),
    .busy  (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_target <= dec.target;
      s1_rd     <= dec.has_cell && !func;
      s1_rom    <= (dec.target == mmbd_pkg::TGT_ROM) ? rom_calc : 22'd0;
      s1_io     <= (dec.target == mmbd_pkg::TGT_IO) ? address[6:0] : 7'd0;
      s1_fw     <= func && (dec.target == mmbd_pkg::TGT_MAPPER
                            || dec.target == mmbd_pkg::TGT_IO);
      s1_fd     <= (func && (dec.target == mmbd_pkg::TGT_MAPPER
                             || dec.target == mmbd_pkg::TGT_IO)) ? write_data : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_move) begin
      target        <= s1_target;
      read_data     <= s1_rd ? mem_rdata : 8'd0;
      rom_address   <= s1_rom;
      io_index      <= s1_io;
      forward_write <= s1_fw;
      forward_data  <= s1_fd;
    end
  end

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted transfer lost");

  a_unused_reads_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && target == mmbd_pkg::TGT_UNUSED |-> read_data == 8'd0)
    else $error("unusable address returned data");

  a_rom_not_forwarded: assert property (@(posedge clk) disable iff (rst)
    out_valid && target == mmbd_pkg::TGT_ROM |-> !forward_write && io_index == 7'd0)
    else $error("ROM read flagged as forwarded");

endmodule

/* rtl/mmbd_store.sv */
`timescale 1ns / 1ps
// Internal byte stores: video/work RAM memory, OAM/high RAM memory, reset clear.
module mmbd_store (
  input  logic               clk,
  input  logic               rst,
  input  mmbd_pkg::mem_req_t req,
  output logic [7:0]         rdata,
  output logic               busy
);

  logic [7:0] main_mem  [mmbd_pkg::MainDepth];
  logic [7:0] small_mem [mmbd_pkg::SmallDepth];
  logic [mmbd_pkg::HramSlots-1:0] hram_valid;

  logic [7:0]                 main_q;
  logic [7:0]                 small_q;
  logic                       sel_q;
  logic                       hv_q;
  logic                       clearing;
  logic [mmbd_pkg::ClrAw-1:0] clr_cnt;

  logic                        main_we;
  logic [mmbd_pkg::MainAw-1:0] main_waddr;
  logic [7:0]                  main_wdata;
  logic                        is_hram;

  assign busy    = clearing;
  assign is_hram = req.small_idx[mmbd_pkg::SmallAw-1];

  always_comb begin
    main_we    = clearing || (req.en && req.we && !req.side);
    main_waddr = clearing ? mmbd_pkg::MainAw'(clr_cnt) : req.main_idx;
    main_wdata = clearing ? 8'd0 : req.wdata;
  end

  always_ff @(posedge clk) begin
    if (main_we) begin
      main_mem[main_waddr] <= main_wdata;
    end
    if (req.en) begin
      main_q <= main_mem[req.main_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (req.en && req.we && req.side) begin
      small_mem[req.small_idx] <= req.wdata;
    end
    if (req.en) begin
      small_q <= small_mem[req.small_idx];
      sel_q   <= req.side;
      hv_q    <= !is_hram || hram_valid[req.small_idx[mmbd_pkg::HramAw-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hram_valid <= '0;
      clearing   <= 1'b1;
      clr_cnt    <= '0;
    end else begin
      if (req.en && req.we && req.side && is_hram) begin
        hram_valid[req.small_idx[mmbd_pkg::HramAw-1:0]] <= 1'b1;
      end
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == mmbd_pkg::ClrAw'(mmbd_pkg::VramBytes - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  assign rdata = sel_q ? (hv_q ? small_q : 8'd0) : main_q;

  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.en)
    else $error("store access during clear pass");

  a_clear_covers_vram: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_cnt) == mmbd_pkg::ClrAw'(mmbd_pkg::VramBytes - 1))
    else $error("clear pass ended early");

  a_hram_valid_set: assert property (@(posedge clk) disable iff (rst)
    req.en && req.we && req.side && is_hram
    |=> hram_valid[$past(req.small_idx[mmbd_pkg::HramAw-1:0])])
    else $error("high RAM valid bit not set after write");

endmodule
